// File: hw/rtl/vmap_pkg.sv
// Shared types, codes and constants for the video memory access port.
package vmap_pkg;

  localparam int MEM_WORDS_DEF = 32768;
  localparam int QUEUE_DEPTH   = 4;
  localparam int OUT_DEPTH     = 8;
  localparam int RECIP_SHIFT   = 30;
  localparam int ADDR_BITS     = 15;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    PORT_MODE    = 3'd0,
    PORT_ADDR_LO = 3'd1,
    PORT_ADDR_HI = 3'd2,
    PORT_DATA_LO = 3'd3,
    PORT_DATA_HI = 3'd4
  } port_sel_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 high;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } op_t;

  function automatic logic [ADDR_BITS-1:0] step_of(input logic [1:0] sel);
    logic [ADDR_BITS-1:0] s;
    unique case (sel)
      2'd0:    s = ADDR_BITS'(1);
      2'd1:    s = ADDR_BITS'(32);
      default: s = ADDR_BITS'(128);
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/vmap_fifo.sv
// Small first-in first-out queue built from registers.
module vmap_fifo import vmap_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign pop_data = store_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: hw/rtl/vmap_front.sv
// Front end: takes bus transactions, keeps mode and address, issues memory operations.
module vmap_front import vmap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_cmd,
  input  logic [2:0] in_port_sel,
  input  logic [7:0] in_write_data,
  input  logic       q_full,
  input  logic       clearing,
  output logic       q_push,
  output op_t        q_op
);

  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [15:0] remap;
  logic        is_data, high, advance;

  assign in_full = q_full || clearing;
  assign q_push  = in_push && !in_full;

  always_comb begin
    unique case (mode_r[3:2])
      2'd1:    remap = {addr_r[15:8], addr_r[4:0], addr_r[7:5]};
      2'd2:    remap = {addr_r[15:9], addr_r[5:0], addr_r[8:6]};
      2'd3:    remap = {addr_r[15:10], addr_r[6:0], addr_r[9:7]};
      default: remap = addr_r;
    endcase
  end

  assign is_data = (in_port_sel == PORT_DATA_LO) || (in_port_sel == PORT_DATA_HI);
  assign high    = (in_port_sel == PORT_DATA_HI);
  assign advance = is_data && (high == mode_r[7]);

  always_comb begin
    q_op.rd   = (in_cmd == CMD_READ) && is_data;
    q_op.wr   = (in_cmd == CMD_WRITE) && is_data;
    q_op.high = high;
    q_op.addr = (in_cmd == CMD_READ) ? remap[ADDR_BITS-1:0] : addr_r[ADDR_BITS-1:0];
    q_op.data = in_write_data;
  end

  always_comb begin
    addr_nxt = addr_r;
    mode_nxt = mode_r;
    if (in_cmd == CMD_WRITE) begin
      unique case (in_port_sel)
        PORT_MODE:    mode_nxt = in_write_data;
        PORT_ADDR_LO: addr_nxt = {addr_r[15:8], in_write_data};
        PORT_ADDR_HI: addr_nxt = {in_write_data, addr_r[7:0]};
        default: ;
      endcase
    end
    if (advance) begin
      addr_nxt = {1'b0, addr_r[ADDR_BITS-1:0] + step_of(mode_r[1:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      mode_r <= '0;
    end else if (q_push) begin
      addr_r <= addr_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: hw/rtl/vmap_back.sv
// Back end: clears the memory after reset, then carries out queued operations in order.
module vmap_back import vmap_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  op_t                          q_op,
  output logic                         q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_cnt,
  output logic                         clearing,
  output logic                         res_push,
  output logic [7:0]                   res_data
);

  localparam int AW    = $clog2(MEM_WORDS);
  localparam int RECIP = ((2 ** RECIP_SHIFT) + MEM_WORDS - 1) / MEM_WORDS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = ADDR_BITS + RW;
  localparam int QW    = PW - RECIP_SHIFT;
  localparam int MW    = 2 * ADDR_BITS;
  localparam int CW    = $clog2(OUT_DEPTH + 1);

  logic [7:0] mem_lo_r [MEM_WORDS];
  logic [7:0] mem_hi_r [MEM_WORDS];

  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  logic                 v1_r, v2_r, v3_r;
  op_t                  op1_r, op2_r, op3_r;
  logic [PW-1:0]        prod1_r;
  logic [AW-1:0]        idx2_r, idx2_nxt;
  logic [7:0]           rd_lo_r, rd_hi_r;
  logic [QW-1:0]        quot;
  logic [MW-1:0]        qm, rem;
  logic [CW:0]          used;
  logic                 issue;
  logic [AW-1:0]        mem_addr;
  logic [7:0]           mem_wdata;
  logic                 we_lo, we_hi;

  assign clearing = clearing_r;
  assign used     = (CW+1)'(out_cnt) + (CW+1)'(v1_r) + (CW+1)'(v2_r) + (CW+1)'(v3_r);
  assign issue    = !q_empty && !clearing_r && (used < (CW+1)'(OUT_DEPTH));
  assign q_pop    = issue;

  // Index reduction by reciprocal multiplication; exact for all 15-bit addresses.
  assign quot     = prod1_r[PW-1:RECIP_SHIFT];
  assign qm       = MW'(quot) * MW'(MEM_WORDS);
  assign rem      = MW'(op1_r.addr) - qm;
  assign idx2_nxt = rem[AW-1:0];

  assign mem_addr  = clearing_r ? clr_cnt_r : idx2_r;
  assign mem_wdata = clearing_r ? 8'h00 : op2_r.data;
  assign we_lo     = clearing_r || (v2_r && op2_r.wr && !op2_r.high);
  assign we_hi     = clearing_r || (v2_r && op2_r.wr && op2_r.high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) clearing_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      op1_r   <= q_op;
      prod1_r <= PW'(q_op.addr) * PW'(RECIP);
    end
    if (v1_r) begin
      op2_r  <= op1_r;
      idx2_r <= idx2_nxt;
    end
    if (v2_r) op3_r <= op2_r;
  end

  always_ff @(posedge clk) begin
    if (we_lo) mem_lo_r[mem_addr] <= mem_wdata;
    if (we_hi) mem_hi_r[mem_addr] <= mem_wdata;
    rd_lo_r <= mem_lo_r[mem_addr];
    rd_hi_r <= mem_hi_r[mem_addr];
  end

  assign res_push = v3_r;
  assign res_data = op3_r.rd ? (op3_r.high ? rd_hi_r : rd_lo_r) : 8'h00;

endmodule

// File: hw/rtl/video_memory_access_port.sv
// Top level of the video memory access port.
// After reset the block sweeps the whole video memory to zero, one word per cycle;
// in_full stays high during that sweep. Afterwards it accepts one bus transaction per
// cycle while in_full is low and returns one result per transaction, in order; a result
// passes the op queue, the back-end pipeline and the result queue to reach the out_
// ports, and read_data is zero for anything but a data read. The sustained rate is one
// transaction per cycle, set by the single port of the byte-wide memory arrays, as long
// as results are popped; the back end stops issuing when its result queue could overflow.
module video_memory_access_port import vmap_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_cmd,
  input  logic [2:0] in_port_sel,
  input  logic [7:0] in_write_data,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_read_data
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  op_t            f_op, b_op;
  logic           f_push, q_full, q_empty, q_pop;
  logic [QCW-1:0] q_cnt;
  logic           clearing;
  logic           res_push, out_full;
  logic [7:0]     res_data;
  logic [OCW-1:0] out_cnt;

  vmap_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_port_sel   (in_port_sel),
    .in_write_data (in_write_data),
    .q_full        (q_full),
    .clearing      (clearing),
    .q_push        (f_push),
    .q_op          (f_op)
  );

  vmap_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (b_op),
    .empty     (q_empty),
    .count     (q_cnt)
  );

  vmap_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_op     (b_op),
    .q_pop    (q_pop),
    .out_cnt  (out_cnt),
    .clearing (clearing),
    .res_push (res_push),
    .res_data (res_data)
  );

  vmap_fifo #(
    .WIDTH (8),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (out_full),
    .pop       (out_pop),
    .pop_data  (out_read_data),
    .empty     (out_empty),
    .count     (out_cnt)
  );

  // The front must hold off while the memory is being swept.
  a_full_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_full)
    else $error("transaction accepted during memory sweep");

  // No operation can be queued before the sweep ends.
  a_queue_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (q_cnt == '0))
    else $error("operation queued during memory sweep");

  // Issue credit keeps the result queue from overflowing.
  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !out_full)
    else $error("result pushed into a full queue");

endmodule

// File: sim/video_memory_access_port_tb.sv
`timescale 1ns / 100ps
// Testbench for the video memory access port: bus transactions checked against a local model.
module video_memory_access_port_tb;
  import vmap_pkg::*;

  localparam int VRAM_WORDS = MEM_WORDS_DEF;
  localparam int LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] PORT_UNUSED_LO = 3'd5;
  localparam logic [2:0] PORT_UNUSED_MID = 3'd6;
  localparam logic [2:0] PORT_UNUSED_HI = 3'd7;
  localparam logic [15:0] ADDR_STEP [4] = '{16'd1, 16'd32, 16'd128, 16'd128};

  typedef struct packed {
    logic       cmd;
    logic [2:0] port;
    logic [7:0] data;
  } bus_txn_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_cmd = 1'b0;
  logic [2:0] in_port_sel = 3'd0;
  logic [7:0] in_write_data = 8'd0;
  logic       out_pop = 1'b0;
  logic       out_empty;
  logic [7:0] out_read_data;

  bus_txn_t   bus_queue[$];
  logic [7:0] read_byte_q[$];
  logic [15:0] vram_model [VRAM_WORDS];
  logic [15:0] addr_reg;
  logic [7:0]  mode_reg;

  bit   push_taken = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   pop_gap = 0;
  int   idle_pct = 15;
  int   err_count = 0;
  int   cycle_count = 0;
  logic [7:0] want_byte;
  bus_txn_t   cur_txn;

  video_memory_access_port uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_cmd       (in_cmd),
    .in_port_sel  (in_port_sel),
    .in_write_data(in_write_data),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_read_data(out_read_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] remap_addr(input logic [15:0] a);
    logic [15:0] r;
    case (mode_reg[3:2])
      2'd1:    r = {a[15:8], a[4:0], a[7:5]};
      2'd2:    r = {a[15:9], a[5:0], a[8:6]};
      2'd3:    r = {a[15:10], a[6:0], a[9:7]};
      default: r = a;
    endcase
    return r;
  endfunction

  function automatic void bump_address(input logic high_byte);
    if (high_byte == mode_reg[7]) begin
      addr_reg = (addr_reg + ADDR_STEP[mode_reg[1:0]]) & 16'h7fff;
    end
  endfunction

  // Applies one bus transaction to the model and returns the byte the bus reads back.
  function automatic logic [7:0] run_bus_txn(input logic cmd, input logic [2:0] port,
                                             input logic [7:0] data);
    logic [7:0]  rd;
    logic [15:0] ra;
    logic [15:0] w;
    int          idx;
    rd = 8'd0;
    idx = int'(addr_reg[14:0]) % VRAM_WORDS;
    if (cmd == CMD_WRITE) begin
      case (port)
        PORT_MODE:    mode_reg = data;
        PORT_ADDR_LO: addr_reg[7:0] = data;
        PORT_ADDR_HI: addr_reg[15:8] = data;
        PORT_DATA_LO: begin
          vram_model[idx][7:0] = data;
          bump_address(1'b0);
        end
        PORT_DATA_HI: begin
          vram_model[idx][15:8] = data;
          bump_address(1'b1);
        end
        default: ;
      endcase
    end else if (port == PORT_DATA_LO || port == PORT_DATA_HI) begin
      ra = remap_addr(addr_reg);
      w = vram_model[int'(ra[14:0]) % VRAM_WORDS];
      rd = (port == PORT_DATA_HI) ? w[15:8] : w[7:0];
      bump_address(port == PORT_DATA_HI);
    end
    return rd;
  endfunction

  task automatic queue_txn(input logic cmd, input logic [2:0] port, input logic [7:0] data);
    bus_txn_t t;
    t.cmd = cmd;
    t.port = port;
    t.data = data;
    bus_queue.push_back(t);
  endtask

  task automatic wait_all_done();
    while (bus_queue.size() != 0 || in_push || read_byte_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly address setup followed by bursts of data accesses, with some mode changes and noise.
  task automatic add_random_traffic(input int goal, input bit allow_idle);
    int         made;
    int         pick;
    int         burst;
    int         k;
    logic       c;
    logic [2:0] p;
    made = 0;
    while (made < goal) begin
      if (allow_idle && $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 30;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_txn(CMD_WRITE, PORT_MODE, 8'($urandom_range(0, 255)));
        made++;
      end else if (pick < 25) begin
        queue_txn(CMD_WRITE, PORT_ADDR_LO, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          queue_txn(CMD_WRITE, PORT_ADDR_HI, 8'($urandom_range(0, 255)));
        end else begin
          queue_txn(CMD_WRITE, PORT_ADDR_HI, 8'($urandom_range(0, 3)));
        end
        made += 2;
      end else if (pick < 88) begin
        burst = $urandom_range(1, 8);
        for (k = 0; k < burst; k++) begin
          p = $urandom_range(0, 1) ? PORT_DATA_HI : PORT_DATA_LO;
          queue_txn(1'($urandom_range(0, 1)), p, 8'($urandom_range(0, 255)));
        end
        made += burst;
      end else begin
        c = 1'($urandom_range(0, 1));
        p = 3'($urandom_range(0, 7));
        queue_txn(c, p, 8'($urandom_range(0, 255)));
        if ((c == CMD_WRITE && p <= PORT_DATA_HI) ||
            (c == CMD_READ && (p == PORT_DATA_LO || p == PORT_DATA_HI))) begin
          made++;
        end
      end
    end
  endtask

  // Driver: presents the next pending transaction once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_push || push_taken)) begin
      if (send_gap > 0 || bus_queue.size() == 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end
        in_push <= 1'b0;
      end else begin
        cur_txn = bus_queue.pop_front();
        in_push <= 1'b1;
        in_cmd <= cur_txn.cmd;
        in_port_sel <= cur_txn.port;
        in_write_data <= cur_txn.data;
        if ($urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 12);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) begin
          pop_gap = $urandom_range(1, 12);
        end
      end
    end
  end

  // Monitor: checks each popped result, then records the expectation of an accepted transaction.
  always @(posedge clk) begin
    push_taken = rst_n && in_push && !in_full;
    if (rst_n && out_pop && !out_empty) begin
      if (read_byte_q.size() == 0) begin
        $error("read_data: unexpected result, actual %0h", out_read_data);
        err_count++;
      end else begin
        want_byte = read_byte_q.pop_front();
        if (out_read_data !== want_byte) begin
          $error("read_data mismatch: expected %0h, actual %0h", want_byte, out_read_data);
          err_count++;
        end
      end
    end
    if (push_taken) begin
      read_byte_q.push_back(run_bus_txn(in_cmd, in_port_sel, in_write_data));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < VRAM_WORDS; k++) begin
      vram_model[k] = 16'd0;
    end
    addr_reg = 16'd0;
    mode_reg = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_txn(CMD_WRITE, PORT_MODE, 8'h00);
    queue_txn(CMD_WRITE, PORT_ADDR_LO, 8'hff);
    queue_txn(CMD_WRITE, PORT_ADDR_HI, 8'hff);
    queue_txn(CMD_WRITE, PORT_DATA_HI, 8'h00);
    queue_txn(CMD_WRITE, PORT_DATA_LO, 8'ha5);
    queue_txn(CMD_WRITE, PORT_ADDR_LO, 8'hff);
    queue_txn(CMD_WRITE, PORT_ADDR_HI, 8'h7f);
    queue_txn(CMD_READ, PORT_DATA_LO, 8'hff);
    queue_txn(CMD_READ, PORT_DATA_HI, 8'h00);
    queue_txn(CMD_WRITE, PORT_UNUSED_LO, 8'hff);
    queue_txn(CMD_WRITE, PORT_UNUSED_HI, 8'h00);
    queue_txn(CMD_READ, PORT_MODE, 8'h00);
    queue_txn(CMD_READ, PORT_ADDR_LO, 8'h00);
    queue_txn(CMD_READ, PORT_ADDR_HI, 8'h00);
    queue_txn(CMD_READ, PORT_UNUSED_MID, 8'h00);
    queue_txn(CMD_WRITE, PORT_MODE, 8'h81);
    queue_txn(CMD_WRITE, PORT_DATA_HI, 8'hff);
    queue_txn(CMD_WRITE, PORT_DATA_LO, 8'h3c);
    queue_txn(CMD_WRITE, PORT_MODE, 8'h8f);
    queue_txn(CMD_READ, PORT_DATA_HI, 8'h00);
    queue_txn(CMD_READ, PORT_DATA_LO, 8'h00);
    queue_txn(CMD_WRITE, PORT_MODE, 8'h06);
    queue_txn(CMD_READ, PORT_DATA_LO, 8'h00);
    queue_txn(CMD_WRITE, PORT_MODE, 8'h0b);
    queue_txn(CMD_READ, PORT_DATA_HI, 8'h00);
    wait_all_done();

    hold_req = 1'b1;
    add_random_traffic(500, 1'b1);
    wait_all_done();
    add_random_traffic(400, 1'b1);
    wait_all_done();
    idle_pct = 0;
    send_gap = 0;
    pop_gap = 0;
    add_random_traffic(300, 1'b0);
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && read_byte_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/vmap_pkg.sv
hw/rtl/vmap_fifo.sv
hw/rtl/vmap_front.sv
hw/rtl/vmap_back.sv
hw/rtl/video_memory_access_port.sv
sim/video_memory_access_port_tb.sv
